// ----- hw/rtl/mvt_pkg.sv -----
// mvt_pkg: shared types, constants and helpers for the 4x4 fp32 transform
// beat structs, matrix reset values, pipeline depths, leading-zero counters
// no dependencies
`timescale 1ns / 1ps

package mvt_pkg;

  localparam int NUM_REGS   = 8;
  localparam int CFG_AW     = 4;
  localparam int MUL_STAGES = 4;
  localparam int ADD_STAGES = 4;
  localparam int LATENCY    = MUL_STAGES + 3 * ADD_STAGES;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [63:0] REG_ONE_LO = 64'h0000_0000_3F80_0000;
  localparam logic [63:0] REG_ONE_HI = 64'h3F80_0000_0000_0000;

  typedef struct packed {
    logic [31:0] in_x;
    logic [31:0] in_y;
    logic [31:0] in_z;
    logic [31:0] in_w;
  } vec_t;

  typedef struct packed {
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [31:0] out_w;
  } res_t;

  function automatic logic [63:0] reg_reset(input logic [2:0] idx);
    logic [63:0] val;
    case (idx)
      3'd0, 3'd5: val = REG_ONE_LO;
      3'd2, 3'd7: val = REG_ONE_HI;
      default:    val = '0;
    endcase
    return val;
  endfunction

  // leading zeros of a 48-bit word, 48 when zero
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] cnt;
    cnt = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) cnt = 6'(47 - i);
    end
    return cnt;
  endfunction

  // leading zeros of a 27-bit word, 27 when zero
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] cnt;
    cnt = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) cnt = 5'(26 - i);
    end
    return cnt;
  endfunction

endpackage

// ----- hw/rtl/mvt_fmul.sv -----
// mvt_fmul: four-stage binary32 multiplier, round to nearest even, subnormals kept
// depends on mvt_pkg
`timescale 1ns / 1ps

module mvt_fmul
  import mvt_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  logic [7:0]  ea, eb, eae, ebe;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  // stage 1: significand product
  logic [47:0]       s1_p;
  logic signed [9:0] s1_sh;
  logic              s1_sign, s1_nan, s1_inf, s1_zero;
  // stage 2: leading zeros
  logic [47:0]       s2_p;
  logic signed [9:0] s2_sh;
  logic [5:0]        s2_lz;
  logic              s2_sign, s2_nan, s2_inf, s2_zero;
  // stage 3: normalized
  logic [47:0]       s3_pn;
  logic              s3_st;
  logic [9:0]        s3_ef;
  logic              s3_sign, s3_nan, s3_inf, s3_zero;

  logic [47:0] pn;
  logic        st;
  logic [9:0]  ef;
  logic [5:0]  rsh;
  logic [47:0] mask;
  logic        up;
  logic [30:0] packed_mag;
  logic [31:0] res;

  always_comb begin
    ea     = a[30:23];
    eb     = b[30:23];
    eae    = (ea == 8'd0) ? 8'd1 : ea;
    ebe    = (eb == 8'd0) ? 8'd1 : eb;
    a_nan  = (&ea) & (|a[22:0]);
    b_nan  = (&eb) & (|b[22:0]);
    a_inf  = (&ea) & ~(|a[22:0]);
    b_inf  = (&eb) & ~(|b[22:0]);
    a_zero = ~(|a[30:0]);
    b_zero = ~(|b[30:0]);
  end

  always_ff @(posedge clk) begin
    s1_p    <= {24'd0, (ea != 8'd0), a[22:0]} * {24'd0, (eb != 8'd0), b[22:0]};
    s1_sh   <= $signed({2'b00, eae}) + $signed({2'b00, ebe}) - 10'sd127;
    s1_sign <= a[31] ^ b[31];
    s1_nan  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    s1_inf  <= a_inf | b_inf;
    s1_zero <= a_zero | b_zero;
  end

  always_ff @(posedge clk) begin
    s2_p    <= s1_p;
    s2_sh   <= s1_sh;
    s2_lz   <= lzc48(s1_p);
    s2_sign <= s1_sign;
    s2_nan  <= s1_nan;
    s2_inf  <= s1_inf;
    s2_zero <= s1_zero;
  end

  // normal when the exponent allows the full shift, else subnormal
  always_comb begin
    pn   = '0;
    st   = 1'b0;
    ef   = '0;
    rsh  = '0;
    mask = '0;
    if (s2_sh >= $signed({4'd0, s2_lz})) begin
      pn = s2_p << s2_lz;
      ef = 10'(s2_sh - $signed({4'd0, s2_lz}) + 10'sd1);
    end else if (s2_sh >= 10'sd0) begin
      pn = s2_p << s2_sh[5:0];
    end else begin
      rsh  = (s2_sh < -10'sd63) ? 6'd63 : 6'(-s2_sh);
      pn   = s2_p >> rsh;
      mask = (rsh >= 6'd48) ? {48{1'b1}} : ((48'd1 << rsh) - 48'd1);
      st   = |(s2_p & mask);
    end
  end

  always_ff @(posedge clk) begin
    s3_pn   <= pn;
    s3_st   <= st;
    s3_ef   <= ef;
    s3_sign <= s2_sign;
    s3_nan  <= s2_nan;
    s3_inf  <= s2_inf;
    s3_zero <= s2_zero;
  end

  always_comb begin
    up = s3_pn[23] & ((|s3_pn[22:0]) | s3_st | s3_pn[24]);
    packed_mag = {s3_ef[7:0], s3_pn[46:24]} + {30'd0, up};
    if (s3_nan)                 res = CANON_NAN;
    else if (s3_inf)            res = {s3_sign, 8'hFF, 23'd0};
    else if (s3_zero)           res = {s3_sign, 31'd0};
    else if (s3_ef >= 10'd255)  res = {s3_sign, 8'hFF, 23'd0};
    else                        res = {s3_sign, packed_mag};
  end

  always_ff @(posedge clk) begin
    p <= res;
  end

endmodule

// ----- hw/rtl/mvt_fadd.sv -----
// mvt_fadd: four-stage binary32 adder, round to nearest even, subnormals kept
// depends on mvt_pkg
`timescale 1ns / 1ps

module mvt_fadd
  import mvt_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] s
);

  logic [31:0] big, sml;
  logic [7:0]  e_big, e_sml, d;
  logic [4:0]  dcap;
  logic [26:0] m_big, m_sml, m_sh, smask;
  logic        a_nan, b_nan, a_inf, b_inf;

  logic [26:0] s1_ml, s1_ms;
  logic [7:0]  s1_e;
  logic        s1_sub, s1_sign, s1_nan, s1_inf, s1_isign, s1_zsign;

  logic [27:0] s2_sum;
  logic [4:0]  s2_lz;
  logic [7:0]  s2_e;
  logic        s2_sign, s2_nan, s2_inf, s2_isign, s2_zsign;

  logic [26:0] s3_x;
  logic [8:0]  s3_e;
  logic        s3_zero, s3_sign, s3_nan, s3_inf, s3_isign, s3_zsign;

  logic [26:0] x;
  logic [8:0]  en;
  logic [4:0]  lsh;
  logic        up;
  logic [30:0] packed_mag;
  logic [31:0] res;

  always_comb begin
    a_nan = (&a[30:23]) & (|a[22:0]);
    b_nan = (&b[30:23]) & (|b[22:0]);
    a_inf = (&a[30:23]) & ~(|a[22:0]);
    b_inf = (&b[30:23]) & ~(|b[22:0]);
    if (a[30:0] < b[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d     = e_big - e_sml;
    dcap  = (d > 8'd31) ? 5'd31 : d[4:0];
    m_big = {(big[30:23] != 8'd0), big[22:0], 3'b000};
    m_sml = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
    smask = (dcap >= 5'd27) ? {27{1'b1}} : ((27'd1 << dcap) - 27'd1);
    m_sh  = (m_sml >> dcap) | {26'd0, |(m_sml & smask)};
  end

  always_ff @(posedge clk) begin
    s1_ml    <= m_big;
    s1_ms    <= m_sh;
    s1_e     <= e_big;
    s1_sub   <= big[31] ^ sml[31];
    s1_sign  <= big[31];
    s1_nan   <= a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]));
    s1_inf   <= a_inf | b_inf;
    s1_isign <= a_inf ? a[31] : b[31];
    s1_zsign <= a[31] & b[31];
  end

  always_ff @(posedge clk) begin
    s2_sum   <= s1_sub ? ({1'b0, s1_ml} - {1'b0, s1_ms}) : ({1'b0, s1_ml} + {1'b0, s1_ms});
    s2_lz    <= lzc27(s1_sub ? (s1_ml - s1_ms) : (s1_ml + s1_ms));
    s2_e     <= s1_e;
    s2_sign  <= s1_sign;
    s2_nan   <= s1_nan;
    s2_inf   <= s1_inf;
    s2_isign <= s1_isign;
    s2_zsign <= s1_zsign;
  end

  // carry-out shifts right once, otherwise shift left no further than exponent 1
  always_comb begin
    lsh = '0;
    if (s2_sum[27]) begin
      x  = {s2_sum[27:2], s2_sum[1] | s2_sum[0]};
      en = {1'b0, s2_e} + 9'd1;
    end else begin
      lsh = ({3'd0, s2_lz} < (s2_e - 8'd1)) ? s2_lz : 5'((s2_e - 8'd1) > 8'd27 ? 8'd27
                                                          : (s2_e - 8'd1));
      x   = s2_sum[26:0] << lsh;
      en  = {1'b0, s2_e} - {4'd0, lsh};
      if (!x[26]) en = '0;
    end
  end

  always_ff @(posedge clk) begin
    s3_x     <= x;
    s3_e     <= en;
    s3_zero  <= (s2_sum == 28'd0);
    s3_sign  <= s2_sign;
    s3_nan   <= s2_nan;
    s3_inf   <= s2_inf;
    s3_isign <= s2_isign;
    s3_zsign <= s2_zsign;
  end

  always_comb begin
    up = s3_x[2] & ((|s3_x[1:0]) | s3_x[3]);
    packed_mag = {s3_e[7:0], s3_x[25:3]} + {30'd0, up};
    if (s3_nan)                res = CANON_NAN;
    else if (s3_inf)           res = {s3_isign, 8'hFF, 23'd0};
    else if (s3_zero)          res = {s3_zsign, 31'd0};
    else if (s3_e >= 9'd255)   res = {s3_sign, 8'hFF, 23'd0};
    else                       res = {s3_sign, packed_mag};
  end

  always_ff @(posedge clk) begin
    s <= res;
  end

endmodule

// ----- hw/rtl/mvt_lane.sv -----
// mvt_lane: one output row, four products then a left-to-right chain of three sums
// depends on mvt_pkg, mvt_fmul, mvt_fadd
`timescale 1ns / 1ps

module mvt_lane
  import mvt_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] m0,
  input  logic [31:0] m1,
  input  logic [31:0] m2,
  input  logic [31:0] m3,
  input  vec_t        v,
  output logic [31:0] row
);

  logic [31:0] p0, p1, p2, p3;
  logic [31:0] acc1, acc2;
  logic [31:0] p2_dly [ADD_STAGES];
  logic [31:0] p3_dly [2*ADD_STAGES];

  mvt_fmul u_mul0 (.clk(clk), .a(m0), .b(v.in_x), .p(p0));
  mvt_fmul u_mul1 (.clk(clk), .a(m1), .b(v.in_y), .p(p1));
  mvt_fmul u_mul2 (.clk(clk), .a(m2), .b(v.in_z), .p(p2));
  mvt_fmul u_mul3 (.clk(clk), .a(m3), .b(v.in_w), .p(p3));

  // later products wait for the running sum
  always_ff @(posedge clk) begin
    p2_dly[0] <= p2;
    for (int i = 1; i < ADD_STAGES; i++) p2_dly[i] <= p2_dly[i-1];
    p3_dly[0] <= p3;
    for (int i = 1; i < 2*ADD_STAGES; i++) p3_dly[i] <= p3_dly[i-1];
  end

  mvt_fadd u_add1 (.clk(clk), .a(p0),   .b(p1),                       .s(acc1));
  mvt_fadd u_add2 (.clk(clk), .a(acc1), .b(p2_dly[ADD_STAGES-1]),     .s(acc2));
  mvt_fadd u_add3 (.clk(clk), .a(acc2), .b(p3_dly[2*ADD_STAGES-1]),   .s(row));

endmodule

// ----- hw/rtl/matrix_vector_transform_4x4.sv -----
// matrix_vector_transform_4x4: top level, matrix registers, four row lanes, result beat
// depends on mvt_pkg, mvt_lane
`timescale 1ns / 1ps

// Transforms one fp32 4-vector by a 4x4 column-major fp32 matrix per clock.
// A beat enters when start is high (busy stays low, so every start is
// taken) and its result appears on result with done high for one cycle;
// each row has 4 multiply stages plus three chained 4-stage adders, and
// a new beat may enter every cycle. The receiver cannot stall, so results
// must be taken as they come. Each product and each partial sum is
// rounded to nearest even, subnormals are kept, and any nan comes out as
// 0x7fc00000. The matrix is written through cfg_we/cfg_addr/cfg_data (two
// elements per 64-bit register, even element in the low half); write it
// only while no beat is in flight. Indexes 8 and up are ignored. After
// reset the matrix is the identity.

module matrix_vector_transform_4x4
  import mvt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  vec_t              in_vec,
  output logic              done,
  output res_t              result,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [63:0]       cfg_data
);

  logic [63:0]        matrix [NUM_REGS];
  logic [LATENCY-1:0] vld;
  logic [31:0]        rows [4];

  // no back-pressure anywhere: the pipe always takes a beat
  assign busy = 1'b0;

  // matrix register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) matrix[i] <= reg_reset(3'(i));
    end else if (cfg_we && (cfg_addr < CFG_AW'(NUM_REGS))) begin
      matrix[cfg_addr[2:0]] <= cfg_data;
    end
  end

  // beat tracking alongside the data pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start & ~busy};
    end
  end

  // row r uses elements r, r+4, r+8, r+12: registers r/2 + 0,2,4,6, same half
  for (genvar r = 0; r < 4; r++) begin : g_lane
    localparam int RI = r / 2;
    localparam int LO = (r % 2) * 32;
    mvt_lane u_lane (
      .clk (clk),
      .m0  (matrix[RI][LO +: 32]),
      .m1  (matrix[RI+2][LO +: 32]),
      .m2  (matrix[RI+4][LO +: 32]),
      .m3  (matrix[RI+6][LO +: 32]),
      .v   (in_vec),
      .row (rows[r])
    );
  end

  // lane outputs are already registered
  assign done         = vld[LATENCY-1];
  assign result.out_x = rows[0];
  assign result.out_y = rows[1];
  assign result.out_z = rows[2];
  assign result.out_w = rows[3];

  // a result only comes out of a beat taken by an earlier start
  a_done_follows_start : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result beat without a matching start");

  // writes past the register list leave the matrix alone
  a_bad_index_ignored : assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_addr >= CFG_AW'(NUM_REGS))) |=> $stable(matrix[0]) && $stable(matrix[7]))
    else $error("out-of-range config write changed the matrix");

  // after reset the diagonal holds one
  a_reset_identity : assert property (@(posedge clk)
    $past(rst) |-> (matrix[0] == REG_ONE_LO) && (matrix[7] == REG_ONE_HI))
    else $error("matrix not identity after reset");

endmodule

// ----- tb/tb.sv -----
// tb: self-checking bench for matrix_vector_transform_4x4, the 4x4 fp32 vertex transform
// depends on mvt_pkg and the rtl top; predicts each beat with its own fp32 model
`timescale 1ns / 1ps

module tb;
  import mvt_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = LATENCY + 4;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  vec_t              in_vec;
  logic              done;
  res_t              result;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [63:0]       cfg_data;

  matrix_vector_transform_4x4 dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_vec(in_vec),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bench copy of the matrix, element e = row + 4*col
  logic [31:0] mat [0:15];
  res_t        expected_q [$];
  int          err_count;
  int          quiet_cycles;
  logic        busy_s;

  // ---------------------------------------------------------------------------
  // fp32 arithmetic through the host double: products of two fp32 are exact in
  // double, and a double sum rounded once more to fp32 still matches a direct
  // fp32 round-to-nearest-even, so only the conversions need care
  // ---------------------------------------------------------------------------

  // exact fp32 -> fp64 bit conversion, subnormals normalized
  function automatic logic [63:0] widen(input logic [31:0] f);
    logic [23:0] m;
    int          ex;
    m = {1'b0, f[22:0]};
    if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, f[22:0], 29'b0};
    if (f[30:0] == '0) return {f[31], 63'b0};
    if (f[30:23] == 8'h00) begin
      ex = 1;
      while (!m[23]) begin
        m = m << 1;
        ex--;
      end
    end else begin
      ex = f[30:23];
    end
    return {f[31], 11'(ex + 896), m[22:0], 29'b0};
  endfunction

  // fp64 -> fp32 with round to nearest even, gradual underflow, nan made canonical
  function automatic logic [31:0] narrow(input logic [63:0] d);
    logic        s;
    int          fe;
    int          sh;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    s = d[63];
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : {s, 8'hFF, 23'b0};
    // double subnormals sit far below half the smallest fp32 subnormal
    if (d[62:52] == 11'h000) return {s, 31'b0};
    fe  = int'(d[62:52]) - 1023 + 127;
    sig = {11'b0, 1'b1, d[51:0]};
    sh  = (fe >= 1) ? 29 : 30 - fe;
    if (sh >= 55) return {s, 31'b0};
    kept = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (fe >= 1) begin
      if (kept[24]) begin
        kept = kept >> 1;
        fe++;
      end
      if (fe >= 255) return {s, 8'hFF, 23'b0};
      return {s, 8'(fe), kept[22:0]};
    end
    // subnormal; a carry into bit 23 lands on the smallest normal by itself
    return {s, kept[30:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    return narrow($realtobits($bitstoreal(widen(a)) * $bitstoreal(widen(b))));
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    return narrow($realtobits($bitstoreal(widen(a)) + $bitstoreal(widen(b))));
  endfunction

  // one row: four rounded products summed left to right
  function automatic logic [31:0] row_dot(input int r, input vec_t v);
    logic [31:0] acc;
    acc = fp_add(fp_mul(mat[r], v.in_x), fp_mul(mat[r + 4], v.in_y));
    acc = fp_add(acc, fp_mul(mat[r + 8], v.in_z));
    return fp_add(acc, fp_mul(mat[r + 12], v.in_w));
  endfunction

  function automatic res_t transform(input vec_t v);
    res_t t;
    t.out_x = row_dot(0, v);
    t.out_y = row_dot(1, v);
    t.out_z = row_dot(2, v);
    t.out_w = row_dot(3, v);
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // busy sampled mid-cycle so the driver sees the value that holds at the next edge
  always @(negedge clk) busy_s <= busy;

  // input side: predict every accepted beat; output side: compare in order
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (start && !busy) expected_q.push_back(transform(in_vec));
      if (done) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat", result.out_x, '0);
        end else begin
          want = expected_q.pop_front();
          if (result.out_x !== want.out_x) report("out_x", result.out_x, want.out_x);
          if (result.out_y !== want.out_y) report("out_y", result.out_y, want.out_y);
          if (result.out_z !== want.out_z) report("out_z", result.out_z, want.out_z);
          if (result.out_w !== want.out_w) report("out_w", result.out_w, want.out_w);
        end
      end
    end
  end

  // watchdog on cycles where no beat moves on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // fp32 value; matrix-style modes pick the range of the matrix words
  localparam int GEN_MIXED = 0;
  localparam int GEN_HUGE  = 1;
  localparam int GEN_TINY  = 2;
  localparam int GEN_RAW   = 3;

  function automatic logic [31:0] rand_fp(input int mode);
    logic [31:0] specials [0:9];
    logic        sgn;
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
                 32'h7F7F_FFFF, 32'h0080_0000};
    sgn = 1'($urandom_range(1));
    case (mode)
      GEN_HUGE: return {sgn, 8'($urandom_range(254, 230)), 23'($urandom)};
      GEN_TINY: return {sgn, 8'($urandom_range(3, 0)), 23'($urandom)};
      GEN_RAW:  return $urandom;
      default: begin
        case ($urandom_range(9))
          0, 1: return $urandom;
          2:    return specials[$urandom_range(9)];
          3:    return {sgn, 8'($urandom_range(20, 0)), 23'($urandom)};
          4:    return {sgn, 8'($urandom_range(254, 230)), 23'($urandom)};
          default: return {sgn, 8'($urandom_range(144, 110)), 23'($urandom)};
        endcase
      end
    endcase
  endfunction

  // register write; write enable is left high for back-to-back writes
  task automatic write_reg(input int idx, input logic [63:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_AW'(idx);
    cfg_data <= val;
    @(posedge clk);
    if (idx < NUM_REGS) begin
      mat[2 * idx]     = val[31:0];
      mat[2 * idx + 1] = val[63:32];
    end
  endtask

  // one input beat: start stays high until the edge that takes it
  task automatic send_vec(input vec_t v);
    in_vec <= v;
    start  <= 1'b1;
    do @(posedge clk); while (busy_s);
  endtask

  task automatic idle_gaps(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // directed rows run against the reset identity
  typedef struct {
    vec_t v;
    bit   known;
    res_t r;
  } row_t;

  row_t dir_rows [$];

  function automatic row_t mk_row(input logic [31:0] x, input logic [31:0] y,
                                  input logic [31:0] z, input logic [31:0] w,
                                  input bit known, input res_t r);
    row_t e;
    e.v     = '{x, y, z, w};
    e.known = known;
    e.r     = r;
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    vec_t v;
    res_t none;
    res_t chk;
    int   idle_pct;
    int   mode;
    logic [63:0] w;

    none         = '0;
    err_count    = 0;
    quiet_cycles = 0;
    busy_s       = 1'b0;
    start        <= 1'b0;
    in_vec       <= '0;
    cfg_we       <= 1'b0;
    cfg_addr     <= '0;
    cfg_data     <= '0;
    rst          <= 1'b1;
    for (int i = 0; i < NUM_REGS; i++) begin
      w              = reg_reset(3'(i));
      mat[2 * i]     = w[31:0];
      mat[2 * i + 1] = w[63:32];
    end

    // zeros, plain values and all-nan come straight through the identity
    dir_rows.push_back(mk_row(0, 0, 0, 0, 1, '0));
    dir_rows.push_back(mk_row(32'h3F80_0000, 32'h4000_0000, 32'hC040_0000, 32'h3F00_0000, 1,
                              '{32'h3F80_0000, 32'h4000_0000, 32'hC040_0000, 32'h3F00_0000}));
    dir_rows.push_back(mk_row('1, '1, '1, '1, 1, '{CANON_NAN, CANON_NAN, CANON_NAN, CANON_NAN}));
    // signed zeros, extremes of range, subnormals
    dir_rows.push_back(mk_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, none));
    dir_rows.push_back(mk_row(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0001, 0, none));
    dir_rows.push_back(mk_row(32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF, 32'h0080_0000, 0, none));
    // infinities: inf times a zero matrix word gives nan, inf minus inf too
    dir_rows.push_back(mk_row(32'h7F80_0000, 32'h3F80_0000, 32'h0, 32'h0, 0, none));
    dir_rows.push_back(mk_row(32'hFF80_0000, 32'h7F80_0000, 32'h4000_0000, 32'hC000_0000, 0, none));
    // nan with an odd payload in one lane only
    dir_rows.push_back(mk_row(32'h3F80_0000, 32'h7F80_0001, 32'h3F80_0000, 32'h3F80_0000, 0, none));
    dir_rows.push_back(mk_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, none));
    dir_rows.push_back(mk_row(32'h7FFF_FFFF, 32'h0, 32'hFFC0_0000, 32'h0, 0, none));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // typed-in expectations are cross-checked against the predictor
    foreach (dir_rows[i]) begin
      chk = transform(dir_rows[i].v);
      if (dir_rows[i].known && chk !== dir_rows[i].r)
        report("directed row", chk.out_x, dir_rows[i].r.out_x);
      send_vec(dir_rows[i].v);
    end
    for (int i = 0; i < 80; i++) send_vec('{rand_fp(GEN_MIXED), rand_fp(GEN_MIXED),
                                            rand_fp(GEN_MIXED), rand_fp(GEN_MIXED)});
    drain();

    // later phases: new matrix, then beats under one idle setting, gap-free for beats 20 to 39
    for (int ph = 1; ph <= 7; ph++) begin
      case (ph)
        1, 5:    idle_pct = 0;
        2, 6:    idle_pct = 85;
        default: idle_pct = 37;
      endcase
      mode = (ph == 2) ? GEN_HUGE : (ph == 3) ? GEN_TINY : (ph == 6) ? GEN_RAW : GEN_MIXED;
      for (int r = 0; r < NUM_REGS; r++) begin
        if (ph == 4) w = '1;
        else if (ph == 7) w = '0;
        else w = {rand_fp(mode), rand_fp(mode)};
        write_reg(r, w);
      end
      // index past the last register must be dropped
      write_reg(NUM_REGS + ph, {$urandom, $urandom});
      cfg_we <= 1'b0;
      @(posedge clk);
      for (int i = 0; i < 100; i++) begin
        // hold off once until the pipeline is empty
        if (ph == 2 && i == 50) drain();
        if (i >= 20 && i < 40) idle_gaps(0);
        else idle_gaps(idle_pct);
        v = '{rand_fp(GEN_MIXED), rand_fp(GEN_MIXED), rand_fp(GEN_MIXED),
              rand_fp(GEN_MIXED)};
        send_vec(v);
      end
      drain();
    end

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
